/* rtl/bounded_event_list_core_defines.svh */
// Assertion macros for the bounded event list core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_EVENT_LIST_CORE_DEFINES_SVH
`define BOUNDED_EVENT_LIST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BEL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bounded_event_list_core: check failed");
`define BEL_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("bounded_event_list_core: forbidden condition");
`else
`define BEL_ASSERT(lbl, clk, rst, prop)
`define BEL_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* rtl/bel_pkg.sv */
// Shared constants, operation codes and control structs for the event list.
// No dependencies.
package bel_pkg;

  localparam int DEPTH     = 64;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = 7;
  localparam int CAP_LIMIT = (DEPTH < 64) ? DEPTH : 64;
  localparam int ENTRY_W   = 64;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_DROP   = 2'd2;
  localparam logic [1:0] FUNC_SEEK   = 2'd3;

  localparam logic [7:0]       NULL_TYPE         = 8'hAA;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 7'd50;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

/* rtl/bel_req_if.sv */
// Request channel: one operation per beat, valid/ready handshake.
// No dependencies.
interface bel_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  position;
  logic [7:0]  event_type;
  logic [7:0]  note_value;
  logic [7:0]  note_data;
  logic [7:0]  channel_number;
  logic [31:0] time_stamp;

  modport source (output valid, func, position, event_type, note_value, note_data,
                  channel_number, time_stamp, input ready);
  modport sink (input valid, func, position, event_type, note_value, note_data,
                channel_number, time_stamp, output ready);
endinterface

/* rtl/bel_rsp_if.sv */
// Response channel: one result per beat, valid/ready handshake.
// No dependencies.
interface bel_rsp_if;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              entry_valid;
  logic [7:0]        out_event_type;
  logic [7:0]        out_value;
  logic [7:0]        out_data;
  logic [7:0]        out_channel;
  logic [31:0]       out_time_stamp;
  logic signed [6:0] seek_index;
  logic [6:0]        list_length;

  modport source (output valid, accepted, entry_valid, out_event_type, out_value,
                  out_data, out_channel, out_time_stamp, seek_index, list_length,
                  input ready);
  modport sink (input valid, accepted, entry_valid, out_event_type, out_value,
                out_data, out_channel, out_time_stamp, seek_index, list_length,
                output ready);
endinterface

/* rtl/bounded_event_list_core.sv */
// Bounded event list: append, read, drop and seek over up to 64 stored entries.
// Append and read go from the accept state straight to the result load; drop at
// position p scans entries p+1 to count-1 and seek scans every entry, one entry
// per cycle through the single RAM read port. One request in flight at a time,
// so a new request beat is taken only when the last response has been or is being taken.
// Synchronous active-high reset empties the list and sets the limit to 50.
module bounded_event_list_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bel_pkg::CNT_W-1:0] cfg_wdata,
  bel_req_if.sink                   req,
  bel_rsp_if.source                 rsp
);

  bel_pkg::ctl_t  ctl;
  bel_pkg::stat_t stat;

  bel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  bel_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .req_func           (req.func),
    .req_position       (req.position),
    .req_event_type     (req.event_type),
    .req_note_value     (req.note_value),
    .req_note_data      (req.note_data),
    .req_channel_number (req.channel_number),
    .req_time_stamp     (req.time_stamp),
    .ctl                (ctl),
    .stat               (stat),
    .accepted           (rsp.accepted),
    .entry_valid        (rsp.entry_valid),
    .out_event_type     (rsp.out_event_type),
    .out_value          (rsp.out_value),
    .out_data           (rsp.out_data),
    .out_channel        (rsp.out_channel),
    .out_time_stamp     (rsp.out_time_stamp),
    .seek_index         (rsp.seek_index),
    .list_length        (rsp.list_length)
  );

endmodule

/* rtl/bel_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bel_datapath.sv */
// Datapath: entry RAM, count and limit registers, scan pointers, result register.
// Depends on bel_pkg, bel_ram and the assertion macros header.
`include "bounded_event_list_core_defines.svh"

module bel_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bel_pkg::CNT_W-1:0] cfg_wdata,
  input  logic [1:0]                req_func,
  input  logic [5:0]                req_position,
  input  logic [7:0]                req_event_type,
  input  logic [7:0]                req_note_value,
  input  logic [7:0]                req_note_data,
  input  logic [7:0]                req_channel_number,
  input  logic [31:0]               req_time_stamp,
  input  bel_pkg::ctl_t             ctl,
  output bel_pkg::stat_t            stat,
  output logic                      accepted,
  output logic                      entry_valid,
  output logic [7:0]                out_event_type,
  output logic [7:0]                out_value,
  output logic [7:0]                out_data,
  output logic [7:0]                out_channel,
  output logic [31:0]               out_time_stamp,
  output logic signed [6:0]         seek_index,
  output logic [6:0]                list_length
);

  localparam int AW = bel_pkg::ADDR_W;
  localparam int CW = bel_pkg::CNT_W;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] max_entries;
  logic [CW-1:0] cap;
  logic [1:0]    op;
  logic [7:0]    key;
  logic          in_range;
  logic          app_ok;
  logic          app_now;
  logic [CW-1:0] rd_ptr;
  logic [AW-1:0] lag_ptr;
  logic          lag_vld;
  logic [6:0]    hit;
  logic          issue;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [bel_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [bel_pkg::ENTRY_W-1:0]   ram_rdata;

  bel_ram #(
    .WIDTH (bel_pkg::ENTRY_W),
    .DEPTH (bel_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cap = (max_entries > CW'(bel_pkg::CAP_LIMIT)) ? CW'(bel_pkg::CAP_LIMIT) : max_entries;
  assign app_now = (req_func == bel_pkg::FUNC_APPEND) && (count < cap);
  assign issue = ctl.scan && (rd_ptr < count);
  assign stat.scan_done = !(rd_ptr < count) && !lag_vld;

  assign ram_raddr = ctl.start ? AW'(req_position) : AW'(rd_ptr);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(count);
    ram_wdata = {req_time_stamp, req_channel_number, req_note_data,
                 req_note_value, req_event_type};
    if (ctl.start && app_now) begin
      ram_we = 1'b1;
    end else if (ctl.scan && lag_vld && (op == bel_pkg::FUNC_DROP)) begin
      ram_we    = 1'b1;
      ram_waddr = lag_ptr - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.start && app_now) begin
      count_next = count + CW'(1);
    end else if (ctl.finish && (op == bel_pkg::FUNC_DROP) && in_range) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      max_entries <= bel_pkg::MAX_ENTRIES_RESET;
      lag_vld     <= 1'b0;
    end else begin
      count   <= count_next;
      lag_vld <= issue;
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op       <= req_func;
      key      <= req_note_value;
      in_range <= {1'b0, req_position} < count;
      app_ok   <= app_now;
      hit      <= '1;
      rd_ptr   <= (req_func == bel_pkg::FUNC_SEEK) ? '0 : CW'(req_position) + CW'(1);
    end else if (ctl.scan) begin
      if (issue) begin
        rd_ptr  <= rd_ptr + CW'(1);
        lag_ptr <= AW'(rd_ptr);
      end
      if (lag_vld && (op == bel_pkg::FUNC_SEEK) && (ram_rdata[15:8] == key)) begin
        hit <= 7'(lag_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      accepted       <= ((op == bel_pkg::FUNC_APPEND) && app_ok) ||
                        ((op == bel_pkg::FUNC_DROP) && in_range);
      entry_valid    <= 1'b0;
      out_event_type <= '0;
      out_value      <= '0;
      out_data       <= '0;
      out_channel    <= '0;
      out_time_stamp <= '0;
      seek_index     <= '1;
      list_length    <= count_next;
      case (op)
        bel_pkg::FUNC_READ: begin
          if (in_range) begin
            entry_valid    <= 1'b1;
            out_event_type <= ram_rdata[7:0];
            out_value      <= ram_rdata[15:8];
            out_data       <= ram_rdata[23:16];
            out_channel    <= ram_rdata[31:24];
            out_time_stamp <= ram_rdata[63:32];
          end else begin
            out_event_type <= bel_pkg::NULL_TYPE;
          end
        end
        bel_pkg::FUNC_SEEK: seek_index <= hit;
        default: ;
      endcase
    end
  end

  `BEL_ASSERT(a_lag_in_scan, clk, rst, lag_vld |-> ctl.scan)
  `BEL_ASSERT(a_count_held_in_scan, clk, rst, ctl.scan |=> $stable(count))
  `BEL_ASSERT_NEVER(a_count_bound, clk, rst, count > CW'(bel_pkg::CAP_LIMIT))

endmodule

/* rtl/bel_ctrl.sv */
// Controller: sequences accept, RAM scan and result load; owns response valid.
// Depends on bel_pkg and the assertion macros header.
`include "bounded_event_list_core_defines.svh"

module bel_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [1:0]     req_func,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  bel_pkg::stat_t stat,
  output bel_pkg::ctl_t  ctl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state, state_next;
  logic       accept;

  assign req_ready  = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept     = req_valid && req_ready;
  assign ctl.start  = accept;
  assign ctl.scan   = (state == S_SCAN);
  assign ctl.finish = (state == S_FINISH);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_func) inside
            bel_pkg::FUNC_DROP, bel_pkg::FUNC_SEEK: state_next = S_SCAN;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `BEL_ASSERT(a_finish_loads, clk, rst, ctl.finish |=> rsp_valid)
  `BEL_ASSERT(a_start_leaves_idle, clk, rst, ctl.start |=> (state != S_IDLE))
  `BEL_ASSERT(a_scan_exit, clk, rst, (ctl.scan && stat.scan_done) |=> ctl.finish)

endmodule

/* bench/bel_list_checker.sv */
// Scoreboard for the bounded event list core: tracks the list and its limit,
// predicts each response beat and compares it field by field.
// Depends on bel_pkg and the bel_req_if / bel_rsp_if interfaces.
`timescale 1ns / 100ps

module bel_list_checker
  import bel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  bel_req_if               req,
  bel_rsp_if               rsp,
  output int               fails,
  output int               outstanding
);

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  channel;
    logic [7:0]  data;
    logic [7:0]  value;
    logic [7:0]  kind;
  } note_entry_t;

  typedef struct packed {
    logic        accepted;
    logic        entry_valid;
    logic [7:0]  kind;
    logic [7:0]  value;
    logic [7:0]  data;
    logic [7:0]  channel;
    logic [31:0] stamp;
    logic [6:0]  seek_index;
    logic [6:0]  length;
  } list_result_t;

  note_entry_t      notes [DEPTH];
  int unsigned      note_count;
  logic [CNT_W-1:0] max_entries;
  list_result_t     pending_results [$];
  int               mismatch_count = 0;
  int               pending_beats = 0;

  assign fails = mismatch_count;
  assign outstanding = pending_beats;

  function automatic list_result_t list_operation(input logic [1:0] op,
                                                  input logic [5:0] pos,
                                                  input note_entry_t item);
    list_result_t r;
    int unsigned  room;
    int unsigned  i;
    r = '0;
    r.seek_index = '1;
    room = max_entries;
    if (room > DEPTH) room = DEPTH;
    if (room > 64) room = 64;
    case (op)
      FUNC_APPEND: begin
        if (note_count < room) begin
          notes[note_count] = item;
          note_count++;
          r.accepted = 1'b1;
        end
      end
      FUNC_READ: begin
        if (pos < note_count) begin
          r.entry_valid = 1'b1;
          r.kind = notes[pos].kind;
          r.value = notes[pos].value;
          r.data = notes[pos].data;
          r.channel = notes[pos].channel;
          r.stamp = notes[pos].stamp;
        end else begin
          r.kind = NULL_TYPE;
        end
      end
      FUNC_DROP: begin
        if (pos < note_count) begin
          for (i = pos; i + 1 < note_count; i++) notes[i] = notes[i + 1];
          note_count--;
          r.accepted = 1'b1;
        end
      end
      default: begin
        for (i = 0; i < note_count; i++)
          if (notes[i].value == item.value) r.seek_index = 7'(i);
      end
    endcase
    r.length = 7'(note_count);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    note_entry_t  item;
    if (rst) begin
      note_count = 0;
      max_entries = MAX_ENTRIES_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we) max_entries = cfg_wdata;
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t response beat with nothing expected", $time);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
          check_field("entry_valid", 32'(want.entry_valid), 32'(rsp.entry_valid));
          check_field("out_event_type", 32'(want.kind), 32'(rsp.out_event_type));
          check_field("out_value", 32'(want.value), 32'(rsp.out_value));
          check_field("out_data", 32'(want.data), 32'(rsp.out_data));
          check_field("out_channel", 32'(want.channel), 32'(rsp.out_channel));
          check_field("out_time_stamp", want.stamp, rsp.out_time_stamp);
          check_field("seek_index", 32'(want.seek_index), 32'(unsigned'(rsp.seek_index)));
          check_field("list_length", 32'(want.length), 32'(rsp.list_length));
        end
      end
      if (req.valid && req.ready) begin
        item = '{stamp: req.time_stamp, channel: req.channel_number, data: req.note_data,
                 value: req.note_value, kind: req.event_type};
        pending_results.push_back(list_operation(req.func, req.position, item));
      end
    end
    pending_beats <= pending_results.size();
  end

endmodule

/* bench/bounded_event_list_core_test.sv */
// Top of the event list bench: clock, reset, request stimulus, response
// back-pressure, limit writes and the verdict. Checking is in bel_list_checker.
// Depends on bel_pkg, the request/response interfaces, the core and bel_list_checker.
`timescale 1ns / 100ps

module bounded_event_list_core_test;
  import bel_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 80;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  bit               quiet = 1'b0;
  bit               rsp_hold = 1'b0;
  int               idle_cycles = 0;
  int               mismatches;
  int               in_flight;

  bel_req_if req();
  bel_rsp_if rsp();

  bounded_event_list_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .rsp      (rsp)
  );

  bel_list_checker list_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .rsp        (rsp),
    .fails      (mismatches),
    .outstanding(in_flight)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // response side: random back-pressure, one long hold-off on request
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
      end else begin
        rsp.ready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [5:0] pos, input logic [7:0] kind,
                      input logic [7:0] value, input logic [7:0] data,
                      input logic [7:0] chan, input logic [31:0] stamp);
    while (!quiet && $urandom_range(99) < 9) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= op;
    req.position <= pos;
    req.event_type <= kind;
    req.note_value <= value;
    req.note_data <= data;
    req.channel_number <= chan;
    req.time_stamp <= stamp;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic send_random(input int append_pct, input int span);
    logic [1:0] op;
    logic [5:0] pos;
    logic [7:0] value;
    if ($urandom_range(99) < append_pct) begin
      op = FUNC_APPEND;
    end else begin
      case ($urandom_range(2))
        0: op = FUNC_READ;
        1: op = FUNC_DROP;
        default: op = FUNC_SEEK;
      endcase
    end
    pos = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(span));
    value = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    send(op, pos, 8'($urandom_range(255)), value, 8'($urandom_range(255)),
         8'($urandom_range(255)), $urandom);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] limit);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    int span;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req.valid <= 1'b0;
    req.func <= FUNC_APPEND;
    req.position <= '0;
    req.event_type <= '0;
    req.note_value <= '0;
    req.note_data <= '0;
    req.channel_number <= '0;
    req.time_stamp <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty list, then appends, reads, seeks and drops under the reset limit
    send(FUNC_READ, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_DROP, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_SEEK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_APPEND, 6'd63, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
    send(FUNC_APPEND, 6'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send(FUNC_APPEND, 6'd0, 8'h12, 8'h34, 8'h56, 8'h78, 32'h9ABC_DEF0);
    send(FUNC_APPEND, 6'd0, 8'hA5, 8'hFF, 8'h5A, 8'h0F, 32'h0000_FFFF);
    send(FUNC_READ, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_READ, 6'd1, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_READ, 6'd3, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_READ, 6'd4, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_READ, 6'd63, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_SEEK, 6'd0, 8'h00, 8'hFF, 8'h00, 8'h00, 32'h0);
    send(FUNC_SEEK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_SEEK, 6'd0, 8'h00, 8'h77, 8'h00, 8'h00, 32'h0);
    send(FUNC_DROP, 6'd1, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_READ, 6'd1, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_DROP, 6'd2, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_DROP, 6'd63, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_DROP, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_READ, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_SEEK, 6'd0, 8'h00, 8'hFF, 8'h00, 8'h00, 32'h0);

    // limit 0, below the current count: every append refused; then limit 12
    write_limit(7'd0);
    repeat (20) send_random(50, 3);
    write_limit(7'd12);
    repeat (40) send_random(50, 15);

    write_limit(7'd64);
    for (n = 0; n < 120; n++) begin
      if (n == 30) rsp_hold = 1'b1;
      if (n == 45) settle();
      quiet = (n >= 60 && n < 100);
      send_random(75, 63);
    end
    repeat (66) send_random(100, 63);
    send(FUNC_READ, 6'd63, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    send(FUNC_SEEK, 6'd0, 8'h00, 8'h03, 8'h00, 8'h00, 32'h0);
    send(FUNC_DROP, 6'd63, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0);
    repeat (8) send_random(30, 63);

    write_limit(7'd3);
    repeat (40) send_random(30, 63);

    repeat (4) begin
      write_limit(7'($urandom_range(64, 1)));
      span = $urandom_range(63, 1);
      repeat (40) send_random(55, span);
    end
    write_limit(MAX_ENTRIES_RESET);
    repeat (40) send_random(50, 31);

    req.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
